// ===== design/ipcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the irrigation pump cycle controller.
// Used by ipcc_moisture and irrigation_pump_cycle_controller.
package ipcc_pkg;

	localparam int ADC_MAX_DEF   = 4095;
	localparam int TIME_BITS_DEF = 32;

	localparam int SOIL_W  = 12;
	localparam int NOW_W   = 32;
	localparam int MOIST_W = 7;
	localparam int THR_W   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_PUMP_ON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOISTURE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOISTURE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIME_MS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS    = 3'd5;

	localparam logic [THR_W-1:0]      MIN_MOISTURE_RST = 7'd0;
	localparam logic [THR_W-1:0]      MAX_MOISTURE_RST = 7'd100;
	localparam logic [CFG_DATA_W-1:0] RUN_TIME_RST     = 32'd10000;
	localparam logic [CFG_DATA_W-1:0] COOLDOWN_RST     = 32'd60000;

	localparam int PCT_FULL = 100;

endpackage

// ===== design/irrigation_pump_cycle_controller.sv =====
`timescale 1ns / 1ps
// Irrigation pump cycle controller top level: config registers, cycle state, result register.
// Depends on ipcc_pkg and ipcc_moisture.
//
// Usage:
//   s_axis carries one soil sample per request: tdata = soil_reading, now_ms.
//   m_axis returns one result per sample: pump_on, moisture_percent, low_alert, phase.
//   cfg_* writes register cfg_index with cfg_data; cfg_ready is always high.
//   Write configuration only while no sample is in flight.
// Path: a sample taken into the input register passes the reciprocal product, correction and
//   moisture stages, then the cycle update into the result register.
// Throughput: one sample per cycle unless m_axis stalls; the cycle state is updated as the
//   sample moves into the result register, so successive samples never wait on it.
// Stall: while m_axis_tready is low the result register holds and up to three more
//   samples are buffered in the moisture pipeline before s_axis_tready drops.
// Reset: arst_n clears the pipeline, sets phase to idle with a start time of zero,
//   manual mode with the pump off, thresholds 0 and 100, run 10000 ms, cooldown 60000 ms.
module irrigation_pump_cycle_controller #(
	parameter int ADC_MAX   = ipcc_pkg::ADC_MAX_DEF,
	parameter int TIME_BITS = ipcc_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [11:0] soil_reading, [43:12] now_ms, [47:44] zero
	input  logic [ipcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] pump_on, [7:1] moisture_percent, [8] low_alert, [10:9] phase, [15:11] zero
	output logic [ipcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ipcc_pkg::*;

	localparam int EW = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_COOL = 2'd2
	} phase_t;

	logic                  auto_mode_q, manual_pump_on_q;
	logic [THR_W-1:0]      min_moisture_q, max_moisture_q;
	logic [CFG_DATA_W-1:0] run_time_q, cooldown_q;

	phase_t                phase_q, phase_d;
	logic [TIME_BITS-1:0]  start_q, start_d;

	logic                  mo_valid, mo_ready;
	logic [MOIST_W-1:0]    mo_moist;
	logic [NOW_W-1:0]      mo_now;

	logic                  res_v_q;
	logic                  pump_q, low_q;
	logic [MOIST_W-1:0]    moist_q;
	phase_t                res_phase_q;

	logic                  take;
	logic                  low_c, pump_c;
	logic [TIME_BITS-1:0]  now_t, elapsed;
	logic                  run_done, cool_done;

	ipcc_moisture #(
		.ADC_MAX(ADC_MAX)
	) u_moist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_reading(s_axis_tdata[SOIL_W-1:0]),
		.in_now    (s_axis_tdata[SOIL_W +: NOW_W]),
		.out_valid (mo_valid),
		.out_ready (mo_ready),
		.out_moist (mo_moist),
		.out_now   (mo_now)
	);

	assign cfg_ready = 1'b1;
	assign mo_ready  = !res_v_q || m_axis_tready;
	assign take      = mo_valid && mo_ready;

	always_comb begin
		now_t     = TIME_BITS'(mo_now);
		elapsed   = now_t - start_q;
		run_done  = EW'(elapsed) >= EW'(run_time_q);
		cool_done = EW'(elapsed) >= EW'(cooldown_q);
		low_c     = mo_moist < min_moisture_q;
		phase_d   = phase_q;
		start_d   = start_q;
		if (auto_mode_q) begin
			if (mo_moist > max_moisture_q) phase_d = PH_IDLE;
			if (low_c) begin
				case (phase_d)
					PH_IDLE: begin
						phase_d = PH_RUN;
						start_d = now_t;
					end
					PH_RUN: begin
						if (run_done) begin
							phase_d = PH_COOL;
							start_d = now_t;
						end
					end
					PH_COOL: begin
						if (cool_done) begin
							phase_d = PH_RUN;
							start_d = now_t;
						end
					end
					default: begin
						phase_d = phase_d;
					end
				endcase
			end else begin
				phase_d = PH_IDLE;
			end
			pump_c = (phase_d == PH_RUN);
		end else begin
			pump_c = manual_pump_on_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q      <= 1'b0;
			manual_pump_on_q <= 1'b0;
			min_moisture_q   <= MIN_MOISTURE_RST;
			max_moisture_q   <= MAX_MOISTURE_RST;
			run_time_q       <= RUN_TIME_RST;
			cooldown_q       <= COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_AUTO_MODE:      auto_mode_q      <= cfg_data[0];
				CFG_MANUAL_PUMP_ON: manual_pump_on_q <= cfg_data[0];
				CFG_MIN_MOISTURE:   min_moisture_q   <= cfg_data[THR_W-1:0];
				CFG_MAX_MOISTURE:   max_moisture_q   <= cfg_data[THR_W-1:0];
				CFG_RUN_TIME_MS:    run_time_q       <= cfg_data;
				CFG_COOLDOWN_MS:    cooldown_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				start_q <= start_d;
			end
			if (mo_ready) res_v_q <= mo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pump_q      <= pump_c;
			low_q       <= low_c;
			moist_q     <= mo_moist;
			res_phase_q <= phase_d;
		end
	end

	assign m_axis_tvalid = res_v_q;
	assign m_axis_tdata  = {5'd0, res_phase_q, low_q, moist_q, pump_q};

endmodule

// ===== design/ipcc_moisture.sv =====
`timescale 1ns / 1ps
// Three-stage moisture pipeline: 100 - floor(reading*100/ADC_MAX), saturated at 0.
// Division by reciprocal multiply with one-step correction. Depends on ipcc_pkg.
module ipcc_moisture #(
	parameter int ADC_MAX = ipcc_pkg::ADC_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ipcc_pkg::SOIL_W-1:0] in_reading,
	input  logic [ipcc_pkg::NOW_W-1:0]  in_now,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ipcc_pkg::MOIST_W-1:0] out_moist,
	output logic [ipcc_pkg::NOW_W-1:0]  out_now
);
	import ipcc_pkg::*;

	localparam int PW    = SOIL_W + 7;
	localparam int KW    = PW + 7;
	localparam int PRODW = SOIL_W + KW;
	localparam int AW    = $clog2(ADC_MAX + 1);
	localparam logic [PW-1:0] RECIP = PW'((1 << PW) / ADC_MAX);
	localparam logic [KW-1:0] K_MUL = KW'(PCT_FULL) * KW'(RECIP);
	localparam logic [AW-1:0] ADC_C = AW'(ADC_MAX);

	logic                 v_s1, v_s2, v_s3;
	logic                 adv_s1, adv_s2, adv_s3;
	logic [SOIL_W-1:0]    rd_s1, rd_s2;
	logic [NOW_W-1:0]     now_s1, now_s2, now_s3;
	logic [PRODW-1:0]     prod_s2;
	logic [MOIST_W-1:0]   moist_s3;

	logic [PW-1:0]        p_val;
	logic [PW-1:0]        q0;
	logic [PW+AW-1:0]     q0_a;
	logic [PW-1:0]        rem;
	logic [PW-1:0]        q;
	logic [MOIST_W-1:0]   moist_c;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		p_val = PW'(rd_s2) * PW'(PCT_FULL);
		q0    = prod_s2[PRODW-1:PW];
		q0_a  = (PW+AW)'(q0) * (PW+AW)'(ADC_C);
		rem   = PW'((PW+AW)'(p_val) - q0_a);
		q     = (rem >= PW'(ADC_C)) ? q0 + PW'(1) : q0;
		if (q >= PW'(PCT_FULL)) begin
			moist_c = '0;
		end else begin
			moist_c = MOIST_W'(PW'(PCT_FULL) - q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			rd_s1  <= in_reading;
			now_s1 <= in_now;
		end
		if (adv_s2 && v_s1) begin
			rd_s2   <= rd_s1;
			now_s2  <= now_s1;
			prod_s2 <= PRODW'(rd_s1) * PRODW'(K_MUL);
		end
		if (adv_s3 && v_s2) begin
			now_s3   <= now_s2;
			moist_s3 <= moist_c;
		end
	end

	assign out_valid = v_s3;
	assign out_moist = moist_s3;
	assign out_now   = now_s3;

endmodule

// ===== test/pump_status_checker.sv =====
`timescale 1ns / 1ps
// Watches the sample, result and register channels of the pump cycle controller and
// predicts each result from its own copy of the registers and the cycle state.
// Depends on ipcc_pkg.
module pump_status_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [ipcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [ipcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ipcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                mismatches,
	output int                                outstanding,
	output int                                results_checked,
	output int                                running_results,
	output int                                cooldown_results
);
	import ipcc_pkg::*;

	typedef enum logic [1:0] {
		PHASE_IDLE = 2'd0,
		PHASE_RUN  = 2'd1,
		PHASE_COOL = 2'd2
	} cycle_phase_e;

	// same layout as m_axis_tdata, lowest bit last
	typedef struct packed {
		logic [4:0]         pad;
		logic [1:0]         phase;
		logic               low_alert;
		logic [MOIST_W-1:0] moisture;
		logic               pump_on;
	} pump_status_t;

	logic                  auto_mode;
	logic                  manual_pump_on;
	logic [THR_W-1:0]      min_moisture;
	logic [THR_W-1:0]      max_moisture;
	logic [CFG_DATA_W-1:0] run_time_ms;
	logic [CFG_DATA_W-1:0] cooldown_ms;
	cycle_phase_e          cycle_phase;
	logic [NOW_W-1:0]      phase_start_ms;
	pump_status_t          status_due[$];
	int                    fail_count;
	int                    checked;
	int                    run_seen;
	int                    cool_seen;

	function automatic pump_status_t next_status(input logic [SOIL_W-1:0] reading,
			input logic [NOW_W-1:0] now);
		pump_status_t     st;
		logic [19:0]      quotient;
		logic [NOW_W-1:0] elapsed;
		st = '0;
		quotient = 20'(reading * PCT_FULL / ADC_MAX_DEF);
		st.moisture = (quotient >= PCT_FULL) ? '0 : MOIST_W'(PCT_FULL - quotient);
		st.low_alert = st.moisture < min_moisture;
		if (auto_mode) begin
			elapsed = now - phase_start_ms;
			if (st.moisture > max_moisture)
				cycle_phase = PHASE_IDLE;
			if (!st.low_alert) begin
				cycle_phase = PHASE_IDLE;
			end else begin
				case (cycle_phase)
					PHASE_IDLE: begin
						cycle_phase = PHASE_RUN;
						phase_start_ms = now;
					end
					PHASE_RUN: begin
						if (elapsed >= run_time_ms) begin
							cycle_phase = PHASE_COOL;
							phase_start_ms = now;
						end
					end
					PHASE_COOL: begin
						if (elapsed >= cooldown_ms) begin
							cycle_phase = PHASE_RUN;
							phase_start_ms = now;
						end
					end
					default: ;
				endcase
			end
			st.pump_on = cycle_phase == PHASE_RUN;
		end else begin
			st.pump_on = manual_pump_on;
		end
		st.phase = cycle_phase;
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		pump_status_t got;
		pump_status_t want;
		if (!arst_n) begin
			auto_mode = 1'b0;
			manual_pump_on = 1'b0;
			min_moisture = MIN_MOISTURE_RST;
			max_moisture = MAX_MOISTURE_RST;
			run_time_ms = RUN_TIME_RST;
			cooldown_ms = COOLDOWN_RST;
			cycle_phase = PHASE_IDLE;
			phase_start_ms = '0;
			status_due.delete();
			fail_count = 0;
			checked = 0;
			run_seen = 0;
			cool_seen = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
			running_results <= 0;
			cooldown_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AUTO_MODE:      auto_mode = cfg_data[0];
					CFG_MANUAL_PUMP_ON: manual_pump_on = cfg_data[0];
					CFG_MIN_MOISTURE:   min_moisture = cfg_data[THR_W-1:0];
					CFG_MAX_MOISTURE:   max_moisture = cfg_data[THR_W-1:0];
					CFG_RUN_TIME_MS:    run_time_ms = cfg_data;
					CFG_COOLDOWN_MS:    cooldown_ms = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result %h with no sample pending", $time, m_axis_tdata);
				end else begin
					want = status_due.pop_front();
					checked++;
					if (want.phase == PHASE_RUN)
						run_seen++;
					if (want.phase == PHASE_COOL)
						cool_seen++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: result %0d expected pump %0d moist %0d alert %0d %s",
								$time, checked, want.pump_on, want.moisture,
								want.low_alert, $sformatf("phase %0d pad %0h",
								want.phase, want.pad));
							$display("%0t: result %0d got      pump %0d moist %0d alert %0d %s",
								$time, checked, got.pump_on, got.moisture,
								got.low_alert, $sformatf("phase %0d pad %0h",
								got.phase, got.pad));
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				status_due.push_back(next_status(s_axis_tdata[SOIL_W-1:0],
					s_axis_tdata[SOIL_W+NOW_W-1:SOIL_W]));
			mismatches <= fail_count;
			outstanding <= status_due.size();
			results_checked <= checked;
			running_results <= run_seen;
			cooldown_results <= cool_seen;
		end
	end

endmodule

// ===== test/irrigation_pump_cycle_controller_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the irrigation pump cycle controller: directed samples,
// then random soil sample streams under a dozen register settings with random stalls.
// Depends on ipcc_pkg, irrigation_pump_cycle_controller and pump_status_checker.
module irrigation_pump_cycle_controller_test;
	import ipcc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTINGS_COUNT = 12;
	localparam int SAMPLES_PER_SETTING = 145;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	int mismatches;
	int outstanding;
	int results_checked;
	int running_results;
	int cooldown_results;

	bit               calm = 1'b0;
	int               idle_cycles = 0;
	int               sent = 0;
	logic [NOW_W-1:0] clock_ms = '0;

	irrigation_pump_cycle_controller dut (.*);

	pump_status_checker checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 80)
			return $urandom_range(1, 400);
		if (r < 95)
			return $urandom_range(401, 20000);
		return $urandom();
	endfunction

	task automatic send_sample(input logic [SOIL_W-1:0] reading, input logic [NOW_W-1:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - SOIL_W - NOW_W){1'b0}}, now, reading};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// hold off new samples until every request has produced its result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// leaves cfg_valid high; caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int                    r;
		int                    streak_left;
		bit                    dry;
		logic [SOIL_W-1:0]     reading;
		logic [THR_W-1:0]      min_v;
		logic [THR_W-1:0]      max_v;
		logic [CFG_DATA_W-1:0] run_v;
		logic [CFG_DATA_W-1:0] cool_v;
		logic                  auto_v;
		streak_left = 0;
		dry = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// manual mode at reset values, reading and time extremes
		send_sample(12'd0, 32'd0);
		send_sample(12'd4095, 32'hFFFF_FFFF);
		send_sample(12'd4094, 32'h8000_0000);
		send_sample(12'd41, 32'd1);
		wait_drained();
		write_reg(CFG_MANUAL_PUMP_ON, 32'h1);
		write_reg(CFG_MIN_MOISTURE, 32'd50);
		write_reg(CFG_MAX_MOISTURE, 32'd80);
		write_reg(CFG_RUN_TIME_MS, 32'd100);
		write_reg(CFG_COOLDOWN_MS, 32'd200);
		cfg_valid <= 1'b0;
		send_sample(12'd2048, 32'd10);
		wait_drained();
		write_reg(CFG_AUTO_MODE, 32'h1);
		cfg_valid <= 1'b0;
		// run, run boundary, cooldown, cooldown boundary
		send_sample(12'd4095, 32'd1000);
		send_sample(12'd4095, 32'd1099);
		send_sample(12'd4095, 32'd1100);
		send_sample(12'd4095, 32'd1299);
		send_sample(12'd4095, 32'd1300);
		// too wet forces idle, a dry sample starts a run, then mid moisture that is not low
		send_sample(12'd0, 32'd1310);
		send_sample(12'd4095, 32'd1320);
		send_sample(12'd2048, 32'd1330);
		// run started just before the time wraps
		send_sample(12'd4095, 32'hFFFF_FFF0);
		wait_drained();
		write_reg(CFG_AUTO_MODE, 32'h0);
		cfg_valid <= 1'b0;
		send_sample(12'd4095, 32'd5);
		wait_drained();
		write_reg(CFG_AUTO_MODE, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_sample(12'd4095, 32'h54);
		wait_drained();
		write_reg(CFG_RUN_TIME_MS, 32'd0);
		write_reg(CFG_COOLDOWN_MS, 32'd0);
		cfg_valid <= 1'b0;
		send_sample(12'd4095, 32'd200);
		send_sample(12'd4095, 32'd200);
		send_sample(12'd4095, 32'd200);
		// minimum above maximum
		wait_drained();
		write_reg(CFG_MIN_MOISTURE, 32'd90);
		write_reg(CFG_MAX_MOISTURE, 32'd20);
		cfg_valid <= 1'b0;
		send_sample(12'd2048, 32'd300);
		// thresholds past 100, upper data bits masked off
		wait_drained();
		write_reg(CFG_MIN_MOISTURE, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_MOISTURE, 32'h0000_FF7F);
		cfg_valid <= 1'b0;
		send_sample(12'd0, 32'd400);
		wait_drained();
		write_reg(CFG_MIN_MOISTURE, 32'h0);
		write_reg(CFG_MAX_MOISTURE, 32'h0);
		write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_sample(12'd4095, 32'd500);
		send_sample(12'd0, 32'd600);

		clock_ms = 32'd1000;
		for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
			calm = (setting % 4) == 1;
			run_v = pick_duration();
			cool_v = pick_duration();
			case (setting)
				0: begin
					min_v = 7'd0;
					max_v = 7'd0;
				end
				1: begin
					min_v = 7'd127;
					max_v = 7'd127;
					run_v = '1;
					cool_v = '0;
				end
				2: begin
					min_v = 7'd100;
					max_v = 7'd100;
					run_v = '0;
					cool_v = '1;
				end
				3: begin
					min_v = 7'd0;
					max_v = 7'd100;
				end
				7: begin
					min_v = THR_W'($urandom_range(80, 100));
					max_v = THR_W'($urandom_range(10, 40));
				end
				default: begin
					min_v = THR_W'($urandom_range(25, 70));
					max_v = THR_W'($urandom_range(72, 99));
				end
			endcase
			auto_v = (setting == 5) ? 1'b0 : ($urandom_range(0, 9) != 0);
			wait_drained();
			write_reg(CFG_AUTO_MODE, ($urandom() & ~32'h1) | auto_v);
			write_reg(CFG_MANUAL_PUMP_ON, $urandom());
			write_reg(CFG_MIN_MOISTURE, ($urandom() & ~32'h7F) | min_v);
			write_reg(CFG_MAX_MOISTURE, ($urandom() & ~32'h7F) | max_v);
			write_reg(CFG_RUN_TIME_MS, run_v);
			write_reg(CFG_COOLDOWN_MS, cool_v);
			cfg_valid <= 1'b0;
			for (int k = 0; k < SAMPLES_PER_SETTING; k++) begin
				if (k == 72)
					wait_drained();
				if (streak_left == 0) begin
					dry = !dry;
					streak_left = $urandom_range(3, 40);
				end
				streak_left--;
				r = $urandom_range(0, 99);
				if (r < 12)
					reading = SOIL_W'($urandom_range(0, 4095));
				else if (dry)
					reading = SOIL_W'($urandom_range(3300, 4095));
				else
					reading = SOIL_W'($urandom_range(0, 900));
				r = $urandom_range(0, 99);
				if (r < 45)
					clock_ms = clock_ms + $urandom_range(0, 30);
				else if (r < 75)
					clock_ms = clock_ms + $urandom_range(0, 300);
				else if (r < 85)
					clock_ms = clock_ms + ($urandom_range(0, 1) ? run_v : cool_v);
				else if (r < 95)
					clock_ms = clock_ms + $urandom_range(0, 3000);
				else
					clock_ms = $urandom();
				send_sample(reading, clock_ms);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d soil samples through %0d random register settings, %0d results checked.",
			sent, SETTINGS_COUNT, results_checked);
		$display("Predicted phases: %0d results while running, %0d in cooldown.",
			running_results, cooldown_results);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
design/ipcc_pkg.sv
design/ipcc_moisture.sv
design/irrigation_pump_cycle_controller.sv
test/pump_status_checker.sv
test/irrigation_pump_cycle_controller_test.sv
